// ----- hw/rtl/mo7gs_pkg.sv -----
// Shared types and codes for the mode-7 ground/sky pixel shader.
`timescale 1ns / 1ps

package mo7gs_pkg;

    // Operation codes carried on the input beat
    typedef enum logic [1:0] {
        OP_GROUND_TEXEL = 2'd0,
        OP_SKY_TEXEL    = 2'd1,
        OP_FRAME        = 2'd2,
        OP_SHADE        = 2'd3
    } t_op;

    // Configuration register indexes
    localparam logic [2:0] CFG_HORIZON_ROW   = 3'd0;
    localparam logic [2:0] CFG_DEPTH_SCALE   = 3'd1;
    localparam logic [2:0] CFG_LATERAL_SCALE = 3'd2;
    localparam logic [2:0] CFG_GROUND_COS    = 3'd3;
    localparam logic [2:0] CFG_GROUND_SIN    = 3'd4;
    localparam logic [2:0] CFG_SKY_COS       = 3'd5;
    localparam logic [2:0] CFG_SKY_SIN       = 3'd6;

    typedef struct packed {
        t_op                op;
        logic [7:0]         pixel_x;
        logic [7:0]         pixel_y;
        logic [15:0]        texel_address;
        logic [23:0]        texel_color;
        logic signed [31:0] frame_ground_offset;
        logic signed [31:0] frame_sky_offset;
        logic [8:0]         frame_flash;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_beat;

endpackage

// ----- hw/rtl/mode7_ground_sky_pixel_shader_core.sv -----
// Top level of the mode-7 ground/sky pixel shader pipeline.
`timescale 1ns / 1ps

// Shades one pixel per clock: a new beat is taken every cycle while the
// output side keeps up. The pipe holds the perspective divide (four stages,
// eight quotient bits each), the wide rotate multiplies and the registered
// texture read. Texel writes and frame updates flow through the same pipe in
// order and give no output beat. A stall on the output holds the whole pipe.
// Texture memories come up undefined and must be loaded before use.
module mode7_ground_sky_pixel_shader_core #(
    parameter int SCREEN_WIDTH    = 256,
    parameter int SCREEN_HEIGHT   = 256,
    parameter int GROUND_TEX_SIZE = 256,
    parameter int SKY_TEX_SIZE    = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mo7gs_pkg::t_in_beat   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mo7gs_pkg::t_out_beat  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [31:0]           i_cfg_data
);

    localparam int NS       = 13;
    localparam int LAST     = NS - 1;
    localparam int G_TB     = $clog2(GROUND_TEX_SIZE);
    localparam int S_TB     = $clog2(SKY_TEX_SIZE);
    localparam logic [8:0] SH      = 9'(SCREEN_HEIGHT);
    localparam logic [9:0] HALF_W  = 10'(SCREEN_WIDTH / 2);
    localparam logic [7:0] G_MASK  = 8'(GROUND_TEX_SIZE - 1);
    localparam logic [7:0] S_MASK  = 8'(SKY_TEX_SIZE - 1);

    typedef struct packed {
        mo7gs_pkg::t_op     op;
        logic               ground;
        logic [7:0]         dy;
        logic signed [9:0]  x_off;
        logic signed [31:0] offset;
        logic signed [15:0] cs;
        logic signed [15:0] sn;
        logic [8:0]         flash;
        logic [15:0]        addr;
        logic [23:0]        color;
        logic [31:0]        dvd;
        logic [8:0]         dvs;
        logic [8:0]         rem;
        logic [31:0]        quo;
        logic [8:0]         span;
        logic [8:0]         blend;
        logic [7:0]         fog_r;
        logic [7:0]         fog_g;
        logic [7:0]         fog_b;
        logic [47:0]        spread;
        logic signed [33:0] wy;
        logic signed [57:0] sx;
        logic signed [63:0] p_sc;
        logic signed [63:0] p_ws;
        logic signed [63:0] p_ss;
        logic signed [63:0] p_wc;
        logic signed [63:0] wx;
        logic signed [63:0] wz;
        logic [7:0]         ch_r;
        logic [7:0]         ch_g;
        logic [7:0]         ch_b;
    } t_item;

    // Configuration and frame state
    logic [7:0]         r_horizon;
    logic [31:0]        r_depth;
    logic [31:0]        r_lateral;
    logic signed [15:0] r_gcos, r_gsin, r_scos, r_ssin;
    logic signed [31:0] r_goff, r_soff;
    logic [8:0]         r_flash;

    t_item       r_p [NS];
    t_item       n_p [NS];
    logic [NS-1:0] r_v, n_v;
    logic          en;

    logic [23:0] r_gmem [65536];
    logic [23:0] r_smem [65536];
    logic [23:0] r_gtex, r_stex;

    // Datapath temporaries
    logic              in_ground;
    logic [7:0]        in_dy;
    logic [63:0]       m_spread;
    logic signed [58:0] m_sx;
    logic signed [73:0] m_sc, m_ss;
    logic signed [49:0] m_ws, m_wc;
    logic [7:0]        tx, ty;
    logic [23:0]       texel;
    logic [16:0]       acc_r, acc_g, acc_b;
    logic [16:0]       fl_r, fl_g, fl_b;

    // One restoring divide step per bit, eight bits per call
    function automatic logic [16:0] div8(input logic [8:0] rem_in,
                                         input logic [7:0] bits_in,
                                         input logic [8:0] dvs_in);
        logic [9:0] t;
        logic [8:0] rm;
        logic [7:0] q;
        rm = rem_in;
        q  = '0;
        for (int j = 7; j >= 0; j--) begin
            t = {rm, bits_in[j]};
            if (t >= {1'b0, dvs_in}) begin
                t    = t - {1'b0, dvs_in};
                q[j] = 1'b1;
            end
            rm = t[8:0];
        end
        return {rm, q};
    endfunction

    // Row fade: 256 - floor(dy*256/span), zero when span is zero or dy reaches it
    function automatic logic [8:0] blend_q8(input logic [7:0] dy_in,
                                            input logic [8:0] span_in);
        logic [16:0] d;
        if (span_in == 9'd0 || {1'b0, dy_in} >= span_in) begin
            return 9'd0;
        end
        d = div8({1'b0, dy_in}, 8'd0, span_in);
        return 9'd256 - {1'b0, d[7:0]};
    endfunction

    // Truncate Q.30 toward zero, drop the low 25 bits, keep the next byte
    function automatic logic [7:0] tex_q(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [7:0]  q;
        mag = v[63] ? (64'd0 - v) : v;
        q   = mag[32:25];
        return v[63] ? (8'd0 - q) : q;
    endfunction

    assign en          = !r_v[LAST] || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_v[LAST];
    assign o_out_data  = '{red: r_p[LAST].ch_r, green: r_p[LAST].ch_g,
                           blue: r_p[LAST].ch_b};

    // Next value of every stage
    always_comb begin
        for (int k = 1; k < NS; k++) begin
            n_p[k] = r_p[k-1];
            n_v[k] = r_v[k-1];
        end

        // entry: pick ground or sky, row distance, divider setup
        in_ground = i_in_data.pixel_y >= r_horizon;
        in_dy     = in_ground ? (i_in_data.pixel_y - r_horizon)
                              : (r_horizon - i_in_data.pixel_y);
        n_v[0]           = i_in_valid;
        n_p[0]           = '0;
        n_p[0].op        = i_in_data.op;
        n_p[0].ground    = in_ground;
        n_p[0].dy        = in_dy;
        n_p[0].x_off     = $signed({2'b00, i_in_data.pixel_x}) - $signed(HALF_W);
        n_p[0].offset    = in_ground ? r_goff : r_soff;
        n_p[0].cs        = in_ground ? r_gcos : r_scos;
        n_p[0].sn        = in_ground ? r_gsin : r_ssin;
        n_p[0].flash     = r_flash;
        n_p[0].addr      = i_in_data.texel_address;
        n_p[0].color     = i_in_data.texel_color;
        n_p[0].dvd       = r_depth;
        n_p[0].dvs       = {1'b0, in_dy} + 9'd1;
        n_p[0].rem       = '0;
        n_p[0].quo       = '0;
        n_p[0].span      = in_ground ? ((SH > {1'b0, r_horizon}) ?
                                        (SH - {1'b0, r_horizon}) : 9'd0)
                                     : {1'b0, r_horizon};

        // perspective divide, eight quotient bits per stage
        {n_p[1].rem, n_p[1].quo[31:24]} = div8(r_p[0].rem, r_p[0].dvd[31:24], r_p[0].dvs);
        n_p[1].blend = blend_q8(r_p[0].dy, r_p[0].span);
        {n_p[2].rem, n_p[2].quo[23:16]} = div8(r_p[1].rem, r_p[1].dvd[23:16], r_p[1].dvs);
        n_p[2].fog_r = r_p[1].ground ? 8'd0 :
                       8'(10'd10 + 10'(({3'b0, r_p[1].blend} * 12'd10) >> 8));
        n_p[2].fog_g = r_p[1].ground ? 8'd0 :
                       8'(10'd20 + 10'(({5'b0, r_p[1].blend} * 14'd20) >> 8));
        n_p[2].fog_b = r_p[1].ground ? 8'd0 :
                       8'(10'd50 + 10'(({5'b0, r_p[1].blend} * 14'd50) >> 8));
        {n_p[3].rem, n_p[3].quo[15:8]}  = div8(r_p[2].rem, r_p[2].dvd[15:8], r_p[2].dvs);
        {n_p[4].rem, n_p[4].quo[7:0]}   = div8(r_p[3].rem, r_p[3].dvd[7:0], r_p[3].dvs);

        // spread and world row
        m_spread      = {32'd0, r_p[4].quo} * {32'd0, r_lateral};
        n_p[5].spread = m_spread[63:16];
        n_p[5].wy     = $signed({{2{r_p[4].offset[31]}}, r_p[4].offset})
                        + $signed({2'b00, r_p[4].quo});

        // screen offset times spread
        m_sx      = r_p[5].x_off * $signed({1'b0, r_p[5].spread});
        n_p[6].sx = m_sx[57:0];

        // rotation products, wrapped or sign-extended to 64 bits
        m_sc = r_p[6].sx * r_p[6].cs;
        m_ss = r_p[6].sx * r_p[6].sn;
        m_ws = r_p[6].wy * r_p[6].sn;
        m_wc = r_p[6].wy * r_p[6].cs;
        n_p[7].p_sc = m_sc[63:0];
        n_p[7].p_ss = m_ss[63:0];
        n_p[7].p_ws = 64'(m_ws);
        n_p[7].p_wc = 64'(m_wc);

        // sky rotation is mirrored
        if (r_p[7].ground) begin
            n_p[8].wx = r_p[7].p_sc - r_p[7].p_ws;
            n_p[8].wz = r_p[7].p_ss + r_p[7].p_wc;
        end else begin
            n_p[8].wx = r_p[7].p_sc + r_p[7].p_ws;
            n_p[8].wz = r_p[7].p_ss - r_p[7].p_wc;
        end

        // texel address, wrapped into the texture
        tx = tex_q(r_p[8].wx) & (r_p[8].ground ? G_MASK : S_MASK);
        ty = tex_q(r_p[8].wz) & (r_p[8].ground ? G_MASK : S_MASK);
        if (r_p[8].op == mo7gs_pkg::OP_SHADE) begin
            n_p[9].addr = r_p[8].ground ? ((16'(ty) << G_TB) | 16'(tx))
                                        : ((16'(ty) << S_TB) | 16'(tx));
        end

        // texture read happens on this edge; only shade beats go on
        n_v[10] = r_v[9] && (r_p[9].op == mo7gs_pkg::OP_SHADE);

        // fade / fog mix
        texel = r_p[10].ground ? r_gtex : r_stex;
        acc_r = (9'd256 - r_p[10].blend) * texel[23:16] + r_p[10].blend * r_p[10].fog_r;
        acc_g = (9'd256 - r_p[10].blend) * texel[15:8]  + r_p[10].blend * r_p[10].fog_g;
        acc_b = (9'd256 - r_p[10].blend) * texel[7:0]   + r_p[10].blend * r_p[10].fog_b;
        n_p[11].ch_r = acc_r[15:8];
        n_p[11].ch_g = acc_g[15:8];
        n_p[11].ch_b = acc_b[15:8];

        // flash toward white, sky only
        fl_r = (8'd255 - r_p[11].ch_r) * r_p[11].flash;
        fl_g = (8'd255 - r_p[11].ch_g) * r_p[11].flash;
        fl_b = (8'd255 - r_p[11].ch_b) * r_p[11].flash;
        if (!r_p[11].ground && r_p[11].flash != 9'd0) begin
            n_p[12].ch_r = r_p[11].ch_r + fl_r[15:8];
            n_p[12].ch_g = r_p[11].ch_g + fl_g[15:8];
            n_p[12].ch_b = r_p[11].ch_b + fl_b[15:8];
        end
    end

    // Control state, configuration and frame registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v       <= '0;
            r_horizon <= 8'd96;
            r_depth   <= 32'd6553600;
            r_lateral <= 32'd65536;
            r_gcos    <= 16'sd16384;
            r_gsin    <= 16'sd0;
            r_scos    <= 16'sd16384;
            r_ssin    <= 16'sd0;
            r_goff    <= '0;
            r_soff    <= '0;
            r_flash   <= '0;
        end else begin
            if (en) begin
                r_v <= n_v;
            end
            if (en && i_in_valid && i_in_data.op == mo7gs_pkg::OP_FRAME) begin
                r_goff  <= i_in_data.frame_ground_offset;
                r_soff  <= i_in_data.frame_sky_offset;
                r_flash <= (i_in_data.frame_flash > 9'd256) ? 9'd256
                                                            : i_in_data.frame_flash;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    mo7gs_pkg::CFG_HORIZON_ROW:   r_horizon <= i_cfg_data[7:0];
                    mo7gs_pkg::CFG_DEPTH_SCALE:   r_depth   <= i_cfg_data;
                    mo7gs_pkg::CFG_LATERAL_SCALE: r_lateral <= i_cfg_data;
                    mo7gs_pkg::CFG_GROUND_COS:    r_gcos    <= $signed(i_cfg_data[15:0]);
                    mo7gs_pkg::CFG_GROUND_SIN:    r_gsin    <= $signed(i_cfg_data[15:0]);
                    mo7gs_pkg::CFG_SKY_COS:       r_scos    <= $signed(i_cfg_data[15:0]);
                    mo7gs_pkg::CFG_SKY_SIN:       r_ssin    <= $signed(i_cfg_data[15:0]);
                    default: ;
                endcase
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NS; k++) begin
                r_p[k] <= n_p[k];
            end
        end
    end

    // Texture memories: writes and reads both at the address stage
    always_ff @(posedge i_clk) begin
        if (en && r_v[9]) begin
            if (r_p[9].op == mo7gs_pkg::OP_GROUND_TEXEL) begin
                r_gmem[r_p[9].addr] <= r_p[9].color;
            end
            if (r_p[9].op == mo7gs_pkg::OP_SKY_TEXEL) begin
                r_smem[r_p[9].addr] <= r_p[9].color;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_gtex <= r_gmem[r_p[9].addr];
            r_stex <= r_smem[r_p[9].addr];
        end
    end

    // Checks
    a_only_shade_after_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[10] |-> r_p[10].op == mo7gs_pkg::OP_SHADE)
        else $error("non-shade beat past texture read");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> r_p[4].rem < r_p[4].dvs)
        else $error("divider remainder not below divisor");

    a_blend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[1] |-> r_p[1].blend <= 9'd256)
        else $error("blend out of range");

    a_ground_no_fog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[2] && r_p[2].ground |-> (r_p[2].fog_r == 8'd0) && (r_p[2].fog_b == 8'd0))
        else $error("fog on ground pixel");

endmodule
